// ===== sv/ihc_pkg.sv =====
package ihc_pkg;

  localparam int HEADER_BYTES = 48;
  localparam int CNT_W        = 7;

  localparam logic [31:0] CRC_POLY    = 32'hEDB8_8320;
  localparam logic [31:0] CRC_ONES    = 32'hFFFF_FFFF;
  localparam logic [31:0] MAGIC_RESET = 32'h4649_5052;

  localparam logic [CNT_W-1:0] MAGIC_END  = CNT_W'(4);
  localparam logic [CNT_W-1:0] CRC_END    = CNT_W'(HEADER_BYTES - 4);
  localparam logic [CNT_W-1:0] HDR_END    = CNT_W'(HEADER_BYTES);
  localparam logic [CNT_W-1:0] HDR_LAST   = CNT_W'(HEADER_BYTES - 1);

  typedef enum logic [1:0] {
    VERDICT_OK    = 2'd0,
    VERDICT_SMALL = 2'd1,
    VERDICT_MAGIC = 2'd2,
    VERDICT_CRC   = 2'd3
  } verdict_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_image;
  } item_t;

  typedef struct packed {
    verdict_t    verdict;
    logic [31:0] computed_crc;
    logic [31:0] stored_crc;
  } result_t;

  // Reflected CRC-32 update by one byte, one bit per step.
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? (CRC_POLY ^ (c >> 1)) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ===== sv/ihc_in_reg.sv =====
module ihc_in_reg import ihc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_stall_src,
  input  logic [7:0] in_data_byte,
  input  logic       in_end_of_image,
  input  logic       take,
  output logic       in_stall,
  output logic       item_valid,
  output item_t      item
);

  logic  valid_r, valid_nxt;
  item_t item_r;
  logic  accept;

  // Hold the byte while the core cannot take it.
  assign in_stall = valid_r && !take;
  assign accept   = in_valid && !in_stall_src;

  always_comb begin
    valid_nxt = valid_r;
    if (accept) begin
      valid_nxt = 1'b1;
    end else if (take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    if (accept) begin
      item_r <= '{data_byte: in_data_byte, end_of_image: in_end_of_image};
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

// ===== sv/ihc_hdr_core.sv =====
module ihc_hdr_core import ihc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        take,
  input  item_t       item,
  input  logic [31:0] magic,
  output logic        res_fire,
  output result_t     res
);

  logic [CNT_W-1:0] byte_count_r, byte_count_nxt;
  logic [31:0]      crc_r, crc_nxt;
  logic             magic_match_r, magic_match_nxt;
  logic [31:0]      stored_r, stored_nxt;
  logic             given_r, given_nxt;
  logic [7:0]       want;
  logic [31:0]      comp;

  assign want = magic[{byte_count_r[1:0], 3'b000} +: 8];
  assign comp = crc_r ^ CRC_ONES;

  always_comb begin
    byte_count_nxt  = byte_count_r;
    crc_nxt         = crc_r;
    magic_match_nxt = magic_match_r;
    stored_nxt      = stored_r;
    given_nxt       = given_r;
    res_fire        = 1'b0;
    res             = '{verdict: VERDICT_SMALL, computed_crc: '0, stored_crc: '0};

    if (!given_r) begin
      if (byte_count_r < MAGIC_END && item.data_byte != want) begin
        magic_match_nxt = 1'b0;
      end
      if (byte_count_r < CRC_END) begin
        crc_nxt = crc_byte(crc_r, item.data_byte);
      end else if (byte_count_r < HDR_END) begin
        stored_nxt = {item.data_byte, stored_r[31:8]};
      end
      if (byte_count_r < HDR_END) begin
        byte_count_nxt = byte_count_r + CNT_W'(1);
      end

      if (byte_count_r == HDR_LAST) begin
        res_fire         = 1'b1;
        given_nxt        = 1'b1;
        res.computed_crc = comp;
        res.stored_crc   = stored_nxt;
        if (!magic_match_nxt) begin
          res.verdict = VERDICT_MAGIC;
        end else if (comp != stored_nxt) begin
          res.verdict = VERDICT_CRC;
        end else begin
          res.verdict = VERDICT_OK;
        end
      end else if (item.end_of_image) begin
        res_fire = 1'b1;
      end
    end

    // End of image rearms for the next one.
    if (item.end_of_image) begin
      byte_count_nxt  = '0;
      crc_nxt         = CRC_ONES;
      magic_match_nxt = 1'b1;
      stored_nxt      = '0;
      given_nxt       = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_count_r  <= '0;
      crc_r         <= CRC_ONES;
      magic_match_r <= 1'b1;
      stored_r      <= '0;
      given_r       <= 1'b0;
    end else if (take) begin
      byte_count_r  <= byte_count_nxt;
      crc_r         <= crc_nxt;
      magic_match_r <= magic_match_nxt;
      stored_r      <= stored_nxt;
      given_r       <= given_nxt;
    end
  end

endmodule

// ===== sv/ihc_out_reg.sv =====
module ihc_out_reg import ihc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        load,
  input  result_t     res,
  input  logic        out_stall,
  output logic        out_free,
  output logic        out_valid,
  output logic [1:0]  out_verdict,
  output logic [31:0] out_computed_crc,
  output logic [31:0] out_stored_crc
);

  logic    valid_r, valid_nxt;
  result_t res_r;

  assign out_free = !valid_r || !out_stall;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (!out_stall) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    if (load) begin
      res_r <= res;
    end
  end

  assign out_valid        = valid_r;
  assign out_verdict      = res_r.verdict;
  assign out_computed_crc = res_r.computed_crc;
  assign out_stored_crc   = res_r.stored_crc;

endmodule

// ===== sv/image_header_crc_checker.sv =====
// Firmware image header checker.
// Input channel: one image byte per transfer (in_data_byte, in_end_of_image
// marks the last byte), handshake in_valid / in_stall.
// Output channel: at most one verdict per image (out_verdict, out_computed_crc,
// out_stored_crc), handshake out_valid / out_stall. Verdict codes: ok, image
// too small, bad magic, CRC mismatch.
// Config channel: cfg_valid / cfg_ready / cfg_wdata writes the expected magic
// word (first byte in bits 7:0); cfg_ready is always high. Write it only while
// the block is idle.
// Path: a byte that causes a verdict is held in the input register; when the core
// stage takes it, the verdict is loaded into the output register. Throughput:
// one byte per cycle while no stall holds it; the core updates the CRC byte-wise.
// Reset (synchronous, rst_n low): both stage registers empty, header state
// rearmed, magic word back to ASCII "RPIF".
// Stall: a held verdict in the output register blocks the core stage; the
// input register then holds its byte and raises in_stall the same cycle.
module image_header_crc_checker import ihc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_end_of_image,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_verdict,
  output logic [31:0] out_computed_crc,
  output logic [31:0] out_stored_crc,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_wdata
);

  logic        item_valid;
  item_t       item;
  logic        take;
  logic        out_free;
  logic        res_fire;
  result_t     res;
  logic [31:0] magic_r;

  // Config register: always ready, written on transfer.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      magic_r <= MAGIC_RESET;
    end else if (cfg_valid && cfg_ready) begin
      magic_r <= cfg_wdata;
    end
  end

  // Advance the core whenever a byte waits and the result slot can take a load.
  assign take = item_valid && out_free;

  ihc_in_reg u_in_reg (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall_src    (in_stall),
    .in_data_byte    (in_data_byte),
    .in_end_of_image (in_end_of_image),
    .take            (take),
    .in_stall        (in_stall),
    .item_valid      (item_valid),
    .item            (item)
  );

  ihc_hdr_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .take     (take),
    .item     (item),
    .magic    (magic_r),
    .res_fire (res_fire),
    .res      (res)
  );

  ihc_out_reg u_out_reg (
    .clk              (clk),
    .rst_n            (rst_n),
    .load             (take && res_fire),
    .res              (res),
    .out_stall        (out_stall),
    .out_free         (out_free),
    .out_valid        (out_valid),
    .out_verdict      (out_verdict),
    .out_computed_crc (out_computed_crc),
    .out_stored_crc   (out_stored_crc)
  );

endmodule

// ===== sv/ihc_checker.sv =====
module ihc_checker import ihc_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  out_verdict,
  input logic [31:0] out_computed_crc,
  input logic [31:0] out_stored_crc
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_verdict)
      && $stable(out_computed_crc) && $stable(out_stored_crc))
    else $error("stalled result changed");

  a_small_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_verdict == VERDICT_SMALL |->
      out_computed_crc == 32'd0 && out_stored_crc == 32'd0)
    else $error("too-small verdict carries CRC values");

  a_ok_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_verdict == VERDICT_OK |-> out_computed_crc == out_stored_crc)
    else $error("ok verdict with differing CRCs");

  a_crc_differ: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_verdict == VERDICT_CRC |-> out_computed_crc != out_stored_crc)
    else $error("mismatch verdict with equal CRCs");

endmodule

bind image_header_crc_checker ihc_checker u_ihc_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_verdict      (out_verdict),
  .out_computed_crc (out_computed_crc),
  .out_stored_crc   (out_stored_crc)
);

// ===== test/image_header_crc_checker_test.sv =====
`timescale 1ns / 1ps

module image_header_crc_checker_test;
  import ihc_pkg::*;

  typedef logic [7:0] byte_q_t[$];

  // Cycles without any transfer before the run is called hung. The longest
  // correct quiet stretch is the receiver hold-off below.
  localparam int QUIET_LIMIT   = 4000;
  localparam int HOLD_OFF_LEN  = 400;
  localparam int RANDOM_BYTES  = 450;
  localparam int RANDOM_VERDICTS = 12;

  logic        clk             = 1'b0;
  logic        rst_n           = 1'b0;
  logic        in_valid        = 1'b0;
  logic        in_stall;
  logic [7:0]  in_data_byte    = 8'h00;
  logic        in_end_of_image = 1'b0;
  logic        out_valid;
  logic        out_stall       = 1'b0;
  logic [1:0]  out_verdict;
  logic [31:0] out_computed_crc;
  logic [31:0] out_stored_crc;
  logic        cfg_valid       = 1'b0;
  logic        cfg_ready;
  logic [31:0] cfg_wdata       = 32'h0;

  // Header state of the predictor, mirrored from the block's behavior.
  logic [31:0] magic_setting = MAGIC_RESET;
  logic [6:0]  hdr_count     = '0;
  logic [31:0] crc_acc       = CRC_ONES;
  logic        magic_ok      = 1'b1;
  logic [31:0] crc_word      = '0;
  logic        verdict_done  = 1'b0;

  result_t expected_verdicts[$];

  // Idle controls for both sides, and the receiver hold-off request.
  bit in_idle_on   = 1'b1;
  bit out_idle_on  = 1'b1;
  int hold_off_req = 0;
  int hold_off_cnt = 0;

  int errors        = 0;
  int verdicts_seen = 0;
  int images_sent   = 0;
  int header_bytes  = 0;
  int magic_writes  = 0;
  int quiet_cycles  = 0;

  image_header_crc_checker i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_data_byte     (in_data_byte),
    .in_end_of_image  (in_end_of_image),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_verdict      (out_verdict),
    .out_computed_crc (out_computed_crc),
    .out_stored_crc   (out_stored_crc),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_wdata        (cfg_wdata)
  );

  always #10 clk = ~clk;

  // Reflected CRC-32, one input bit per step, LSB first.
  function automatic logic [31:0] crc32_step(input logic [31:0] acc, input logic [7:0] b);
    logic [31:0] r;
    r = acc;
    for (int i = 0; i < 8; i++) begin
      r = (r >> 1) ^ (CRC_POLY & {32{r[0] ^ b[i]}});
    end
    return r;
  endfunction

  // Build a full header: magic in bytes 0..3, body per fill mode
  // (0 zeros, 1 all ones, 2 random), correct CRC stored little-endian.
  function automatic byte_q_t make_header(input logic [31:0] magic, input int fill);
    byte_q_t     hdr;
    logic [31:0] acc;
    logic [31:0] comp;
    acc = CRC_ONES;
    for (int i = 0; i < HEADER_BYTES - 4; i++) begin
      if (i < 4)
        hdr.push_back(magic[8*i +: 8]);
      else if (fill == 0)
        hdr.push_back(8'h00);
      else if (fill == 1)
        hdr.push_back(8'hFF);
      else
        hdr.push_back(8'($urandom));
      acc = crc32_step(acc, hdr[i]);
    end
    comp = ~acc;
    for (int i = 0; i < 4; i++) hdr.push_back(comp[8*i +: 8]);
    return hdr;
  endfunction

  function automatic void rearm_predictor();
    hdr_count    = '0;
    crc_acc      = CRC_ONES;
    magic_ok     = 1'b1;
    crc_word     = '0;
    verdict_done = 1'b0;
  endfunction

  // Advance the predictor by one transferred byte; queue the verdict it causes.
  function automatic void predict_header_byte(input logic [7:0] b, input logic eoi);
    result_t     r;
    logic [7:0]  want;
    logic [31:0] comp;
    if (!verdict_done) begin
      header_bytes++;
      if (hdr_count < 4) begin
        want = 8'(magic_setting >> (8 * hdr_count));
        if (b != want) magic_ok = 1'b0;
      end
      if (hdr_count < HEADER_BYTES - 4)
        crc_acc = crc32_step(crc_acc, b);
      else if (hdr_count < HEADER_BYTES)
        crc_word = {b, crc_word[31:8]};
      if (hdr_count == HEADER_BYTES - 1) begin
        comp = ~crc_acc;
        if (!magic_ok)
          r.verdict = VERDICT_MAGIC;
        else if (comp != crc_word)
          r.verdict = VERDICT_CRC;
        else
          r.verdict = VERDICT_OK;
        r.computed_crc = comp;
        r.stored_crc   = crc_word;
        verdict_done   = 1'b1;
        expected_verdicts.push_back(r);
      end else if (eoi) begin
        r = '{VERDICT_SMALL, 32'h0, 32'h0};
        expected_verdicts.push_back(r);
      end
      if (hdr_count < HEADER_BYTES) hdr_count = hdr_count + 7'd1;
    end
    if (eoi) rearm_predictor();
  endfunction

  // Offer one byte from a falling edge, with random idle cycles first, and
  // hold it until the transfer happens.
  task automatic send_byte(input logic [7:0] b, input logic eoi);
    @(negedge clk);
    while (in_idle_on && $urandom_range(0, 99) < 26) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid        <= 1'b1;
    in_data_byte    <= b;
    in_end_of_image <= eoi;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_header_byte(b, eoi);
  endtask

  // Send a whole image; the mark goes on its last byte.
  task automatic send_image(input byte_q_t img);
    for (int i = 0; i < img.size(); i++) send_byte(img[i], i == img.size() - 1);
    images_sent++;
  endtask

  // Drop valid, drain every expected verdict, then allow the pipeline latency.
  task automatic wait_until_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_verdicts.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write the magic register; call only while the block is idle.
  task automatic write_magic(input logic [31:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    magic_setting = value;
    magic_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Random image: mostly well-formed headers with random content, the rest
  // corrupted CRC, corrupted magic, truncated images and plain noise.
  task automatic send_random_image();
    byte_q_t img;
    int      kind;
    int      n;
    kind = $urandom_range(0, 99);
    img  = make_header(magic_setting, 2);
    if (kind >= 55 && kind < 70) begin
      n = 44 + $urandom_range(0, 3);
      img[n] = img[n] ^ 8'(1 << $urandom_range(0, 7));
    end else if (kind >= 70 && kind < 80) begin
      n = $urandom_range(0, 3);
      img[n] = img[n] ^ 8'(1 << $urandom_range(0, 7));
    end else if (kind >= 80 && kind < 93) begin
      n = $urandom_range(1, HEADER_BYTES - 1);
      while (img.size() > n) void'(img.pop_back());
    end else if (kind >= 93) begin
      img.delete();
      n = $urandom_range(1, HEADER_BYTES + 12);
      repeat (n) img.push_back(8'($urandom));
    end
    // Trailing payload after a complete header is ignored until the mark.
    if (kind < 80) repeat ($urandom_range(0, 4)) img.push_back(8'($urandom));
    send_image(img);
  endtask

  task automatic test_default_magic();
    byte_q_t img;
    // Good header, zero body, payload after it.
    img = make_header(MAGIC_RESET, 0);
    repeat (3) img.push_back(8'hA5);
    send_image(img);
    // Good header with the mark right on its final byte.
    send_image(make_header(MAGIC_RESET, 1));
    wait_until_idle();
  endtask

  task automatic test_short_images();
    byte_q_t img;
    // Mark on the very first byte.
    img.delete();
    img.push_back(8'hFF);
    send_image(img);
    // One byte short of a full header.
    img = make_header(magic_setting, 2);
    void'(img.pop_back());
    send_image(img);
    // Short image that stops inside the magic word.
    img.delete();
    for (int i = 0; i < 3; i++) img.push_back(magic_setting[8*i +: 8]);
    send_image(img);
    wait_until_idle();
  endtask

  task automatic test_bad_headers();
    byte_q_t img;
    // Bad magic with a consistent CRC over the wrong bytes.
    send_image(make_header(~magic_setting, 0));
    // Bad magic and a broken CRC: magic wins.
    img = make_header(magic_setting, 2);
    img[1] = img[1] ^ 8'h80;
    img[47] = img[47] ^ 8'h01;
    send_image(img);
    // Good magic, broken CRC.
    img = make_header(magic_setting, 1);
    img[44] = img[44] ^ 8'h01;
    img.push_back(8'h00);
    send_image(img);
    wait_until_idle();
  endtask

  task automatic test_magic_extremes();
    write_magic(32'h0000_0000);
    send_image(make_header(32'h0000_0000, 0));
    wait_until_idle();
    write_magic(32'hFFFF_FFFF);
    send_image(make_header(32'hFFFF_FFFF, 1));
    send_image(make_header(32'h0000_0000, 0));
    wait_until_idle();
  endtask

  // Hold the receiver off while short images keep coming, so the output
  // register fills and the block stalls its input.
  task automatic test_back_pressure();
    byte_q_t img;
    hold_off_req += HOLD_OFF_LEN;
    repeat (20) begin
      img.delete();
      repeat ($urandom_range(1, 3)) img.push_back(8'($urandom));
      send_image(img);
    end
    send_image(make_header(magic_setting, 2));
    wait_until_idle();
  endtask

  task automatic test_random_images();
    int byte_goal;
    int verdict_goal;
    int phase;
    byte_goal    = header_bytes + RANDOM_BYTES;
    verdict_goal = verdicts_seen + RANDOM_VERDICTS;
    phase        = 0;
    while (header_bytes < byte_goal || verdicts_seen < verdict_goal) begin
      // Phase two runs with no idling on either side.
      in_idle_on  = (phase != 2);
      out_idle_on = (phase != 2);
      case ($urandom_range(0, 5))
        0: write_magic(32'h0000_0000);
        1: write_magic(32'hFFFF_FFFF);
        2: write_magic(MAGIC_RESET);
        default: write_magic($urandom);
      endcase
      repeat (3) send_random_image();
      wait_until_idle();
      phase++;
    end
    in_idle_on  = 1'b1;
    out_idle_on = 1'b1;
  endtask

  // Receiver: random stalls, or a counted hold-off when one is requested.
  always @(negedge clk) begin
    if (hold_off_cnt < hold_off_req) begin
      out_stall    <= 1'b1;
      hold_off_cnt <= hold_off_cnt + 1;
    end else begin
      out_stall <= out_idle_on && ($urandom_range(0, 99) < 26);
    end
  end

  // Compare each verdict transfer with the oldest expectation.
  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_valid && !out_stall) begin
      verdicts_seen++;
      if (expected_verdicts.size() == 0) begin
        errors++;
        $display("%0t: unexpected verdict, expected none, actual %0d crc %h stored %h",
                 $time, out_verdict, out_computed_crc, out_stored_crc);
      end else begin
        want = expected_verdicts.pop_front();
        if (out_verdict != want.verdict) begin
          errors++;
          $display("%0t: verdict mismatch, expected %0d, actual %0d",
                   $time, want.verdict, out_verdict);
        end
        if (out_computed_crc != want.computed_crc) begin
          errors++;
          $display("%0t: computed_crc mismatch, expected %h, actual %h",
                   $time, want.computed_crc, out_computed_crc);
        end
        if (out_stored_crc != want.stored_crc) begin
          errors++;
          $display("%0t: stored_crc mismatch, expected %h, actual %h",
                   $time, want.stored_crc, out_stored_crc);
        end
      end
    end
  end

  // Watchdog: end the run when no transfer happens for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: watchdog, no transfer for %0d cycles, %0d verdicts pending",
               $time, quiet_cycles, expected_verdicts.size());
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_default_magic();
    test_short_images();
    test_bad_headers();
    test_magic_extremes();
    test_back_pressure();
    test_random_images();

    wait_until_idle();
    repeat (8) @(posedge clk);

    $display("Covered %0d images (%0d header bytes) over %0d magic settings,",
             images_sent, header_bytes, magic_writes);
    $display("with %0d verdicts checked under random and held-off back pressure.",
             verdicts_seen);
    if (errors == 0 && expected_verdicts.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches, %0d verdicts never arrived", errors, expected_verdicts.size());
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
